// ===== rtl/core/bqf_pkg.sv =====
`default_nettype none

package bqf_pkg;

	localparam int SAMPLE_WIDTH  = 24;
	localparam int COEF_WIDTH    = 24;
	localparam int HISTORY_WIDTH = 32;
	localparam int COEF_FRAC     = COEF_WIDTH - 4;
	localparam int NUM_COEFS     = 5;
	localparam int LANES         = 3;
	localparam int IDX_W         = $clog2(NUM_COEFS);
	localparam int CNT_W         = $clog2(COEF_WIDTH);
	// three lanes of sums plus the sign need three guard bits
	localparam int ACC_HI_W      = HISTORY_WIDTH + 3;
	localparam int ACC_W         = ACC_HI_W + COEF_WIDTH;
	localparam int RND_W         = ACC_W - COEF_FRAC;

	localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

	typedef enum logic [IDX_W-1:0] {
		IDX_B0 = IDX_W'(0),
		IDX_B1 = IDX_W'(1),
		IDX_B2 = IDX_W'(2),
		IDX_A1 = IDX_W'(3),
		IDX_A2 = IDX_W'(4)
	} coef_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FBK,
		ST_WSAT,
		ST_FWD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} mac_ctrl_t;

	// round half up to the sample step
	function automatic logic signed [RND_W-1:0] rnd(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		t = acc + (ACC_W'(1) << (COEF_FRAC - 1));
		return RND_W'(t >>> COEF_FRAC);
	endfunction

	function automatic logic signed [HISTORY_WIDTH-1:0] sat_hist(
		input logic signed [RND_W-1:0] r
	);
		logic signed [RND_W-1:0] hi;
		logic signed [RND_W-1:0] lo;
		hi = {{(RND_W-HISTORY_WIDTH+1){1'b0}}, {(HISTORY_WIDTH-1){1'b1}}};
		lo = ~hi;
		if (r > hi)
			return hi[HISTORY_WIDTH-1:0];
		else if (r < lo)
			return lo[HISTORY_WIDTH-1:0];
		else
			return r[HISTORY_WIDTH-1:0];
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(
		input logic signed [RND_W-1:0] r
	);
		logic signed [RND_W-1:0] hi;
		logic signed [RND_W-1:0] lo;
		hi = {{(RND_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
		lo = ~hi;
		if (r > hi)
			return hi[SAMPLE_WIDTH-1:0];
		else if (r < lo)
			return lo[SAMPLE_WIDTH-1:0];
		else
			return r[SAMPLE_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/biquad_iir_filter.sv =====
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    sample_in
// out       out  out_valid/out_ready  sample_out
// cfg       in   cfg_we               cfg_index, cfg_data
//
// Each sample is taken by an input transfer in idle, then runs two passes
// through the bit-serial multiply-accumulate, each over the COEF_WIDTH
// coefficient bits and each followed by a state that latches its result. The
// output register is loaded after the second pass. A new sample is taken only in idle.
// The output register frees the input while a result waits; the block stalls
// before updating history if the previous result is still untaken.
// Reset clears history, restores b0 = 1.0 and empties the output.
`default_nettype none

module biquad_iir_filter import bqf_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	input  wire logic                           cfg_we,
	input  wire logic [IDX_W-1:0]               cfg_index,
	input  wire logic [COEF_WIDTH-1:0]          cfg_data
);

	state_t                            state_q, state_d;
	logic [CNT_W-1:0]                  cnt_q;
	logic signed [COEF_WIDTH-1:0]      coef_q [NUM_COEFS];
	logic signed [HISTORY_WIDTH-1:0]   d1_q, d2_q, w_q;
	logic signed [SAMPLE_WIDTH-1:0]    x_q, y_q;
	logic                              out_valid_q;
	logic                              load_out;
	logic                              phase2;
	mac_ctrl_t                         mac_ctrl;
	logic signed [COEF_WIDTH-1:0]      mac_coef [LANES];
	logic signed [HISTORY_WIDTH-1:0]   mac_data [LANES];
	logic [LANES-1:0]                  mac_neg;
	logic signed [ACC_W-1:0]           acc;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COEF_WIDTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		mac_ctrl = '0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mac_ctrl.load = 1'b1;
					state_d       = ST_FBK;
				end
			end
			ST_FBK: begin
				mac_ctrl.step = 1'b1;
				mac_ctrl.last = (cnt_q == CNT_LAST);
				if (mac_ctrl.last)
					state_d = ST_WSAT;
			end
			ST_WSAT: begin
				mac_ctrl.load = 1'b1;
				state_d       = ST_FWD;
			end
			ST_FWD: begin
				mac_ctrl.step = 1'b1;
				mac_ctrl.last = (cnt_q == CNT_LAST);
				if (mac_ctrl.last)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (mac_ctrl.step && !mac_ctrl.last)
			cnt_q <= cnt_q + 1'b1;
		else
			cnt_q <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[IDX_B0] <= COEF_ONE;
			coef_q[IDX_B1] <= '0;
			coef_q[IDX_B2] <= '0;
			coef_q[IDX_A1] <= '0;
			coef_q[IDX_A2] <= '0;
		end else if (cfg_we && (cfg_index < IDX_W'(NUM_COEFS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// feedback pass: x*1.0 - a1*d1 - a2*d2; feedforward pass: b0*w + b1*d1 + b2*d2
	assign phase2 = (state_q == ST_WSAT) || (state_q == ST_FWD);

	always_comb begin
		if (phase2) begin
			mac_coef[0] = coef_q[IDX_B0];
			mac_coef[1] = coef_q[IDX_B1];
			mac_coef[2] = coef_q[IDX_B2];
			mac_data[0] = w_q;
			mac_neg     = '0;
		end else begin
			mac_coef[0] = COEF_ONE;
			mac_coef[1] = coef_q[IDX_A1];
			mac_coef[2] = coef_q[IDX_A2];
			mac_data[0] = {{(HISTORY_WIDTH-SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q};
			mac_neg     = 3'b110;
		end
		mac_data[1] = d1_q;
		mac_data[2] = d2_q;
	end

	bqf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (mac_coef),
		.data   (mac_data),
		.neg    (mac_neg),
		.acc    (acc)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			x_q <= sample_in;
		if (state_q == ST_WSAT)
			w_q <= sat_hist(rnd(acc));
		if (load_out)
			y_q <= sat_smp(rnd(acc));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (load_out) begin
			d1_q <= w_q;
			d2_q <= d1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = y_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_FBK && cnt_q == '0)
		else $error("feedback pass did not start after input transfer");

	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FWD && cnt_q == CNT_LAST |=> state_q == ST_OUT)
		else $error("feedforward pass did not end after COEF_WIDTH steps");

	a_hist: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(d1_q) |-> $past(load_out))
		else $error("history moved without a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/core/bqf_mac.sv =====
`default_nettype none

module bqf_mac import bqf_pkg::*; (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mac_ctrl_t                       ctrl,
	input  wire logic signed [COEF_WIDTH-1:0]    coef [LANES],
	input  wire logic signed [HISTORY_WIDTH-1:0] data [LANES],
	input  wire logic [LANES-1:0]                neg,
	output logic signed [ACC_W-1:0]              acc
);

	logic [COEF_WIDTH-1:0]      coef_sr_q [LANES];
	logic signed [ACC_HI_W-1:0] hi_q;
	logic [COEF_WIDTH-1:0]      lo_q;
	logic signed [ACC_HI_W-1:0] sum;

	// coefficient bits LSB first; the sign bit weighs negative
	always_comb begin
		logic signed [ACC_HI_W-1:0] dx;
		sum = hi_q;
		for (int k = 0; k < LANES; k++) begin
			dx = {{(ACC_HI_W-HISTORY_WIDTH){data[k][HISTORY_WIDTH-1]}}, data[k]};
			if (coef_sr_q[k][0])
				sum = (neg[k] ^ ctrl.last) ? sum - dx : sum + dx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctrl.load) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctrl.step) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[COEF_WIDTH-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			if (ctrl.load)
				coef_sr_q[k] <= coef[k];
			else if (ctrl.step)
				coef_sr_q[k] <= coef_sr_q[k] >> 1;
		end
	end

	assign acc = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== tb/biquad_iir_filter_tb.sv =====
`timescale 1ns / 100ps

module biquad_iir_filter_tb;
	import bqf_pkg::*;

	localparam int ONE            = 1 << COEF_FRAC;
	localparam int NUM_IDX        = 1 << IDX_W;
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_ITEMS    = 72;
	localparam int BURST_PHASE    = 4;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 10000;

	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
	localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           cfg_we    = 1'b0;
	logic [IDX_W-1:0]               cfg_index = '0;
	logic [COEF_WIDTH-1:0]          cfg_data  = '0;

	// filter mirror: coefficients and the two delayed internal values
	longint coef_mirror [NUM_COEFS];
	longint hist_first  = 0;
	longint hist_second = 0;

	logic signed [SAMPLE_WIDTH-1:0] sample_queue [$];
	logic signed [SAMPLE_WIDTH-1:0] expected_out [$];
	logic signed [SAMPLE_WIDTH-1:0] wanted;

	int   items_queued = 0;
	int   items_taken  = 0;
	int   errors       = 0;
	int   idle_cycles  = 0;
	logic in_taken     = 1'b0;
	int   tx_gap       = 0;
	int   rx_hold      = 0;
	bit   tx_steady    = 1'b0;
	bit   rx_steady    = 1'b0;
	int   hold_asked   = 0;
	int   hold_done    = 0;

	biquad_iir_filter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		coef_mirror[IDX_B0] = longint'(COEF_ONE);
		coef_mirror[IDX_B1] = 0;
		coef_mirror[IDX_B2] = 0;
		coef_mirror[IDX_A1] = 0;
		coef_mirror[IDX_A2] = 0;
	end

	// round half up to the sample step
	function automatic longint round_q(input longint acc);
		return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
	endfunction

	function automatic longint clamp(input longint v, input int width);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (width - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		else if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] filter_step(
		input logic signed [SAMPLE_WIDTH-1:0] x
	);
		longint acc;
		longint w;
		acc = (longint'(x) <<< COEF_FRAC) - coef_mirror[IDX_A1] * hist_first
			- coef_mirror[IDX_A2] * hist_second;
		w = clamp(round_q(acc), HISTORY_WIDTH);
		acc = coef_mirror[IDX_B0] * w + coef_mirror[IDX_B1] * hist_first
			+ coef_mirror[IDX_B2] * hist_second;
		hist_second = hist_first;
		hist_first  = w;
		return SAMPLE_WIDTH'(clamp(round_q(acc), SAMPLE_WIDTH));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 8);
		return $urandom_range(30, 150);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
		else if (r < 3)
			return SAMPLE_WIDTH'(int'($urandom_range(0, 510)) - 255);
		return SAMPLE_WIDTH'($urandom);
	endfunction

	function automatic logic signed [COEF_WIDTH-1:0] extreme_coef();
		case ($urandom_range(0, 2))
			0: return COEF_MIN;
			1: return COEF_MAX;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [COEF_WIDTH-1:0] rand_gain();
		return COEF_WIDTH'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
	endfunction

	task automatic write_coef(input logic [IDX_W-1:0] idx,
		input logic signed [COEF_WIDTH-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx < NUM_COEFS)
			coef_mirror[idx] = longint'(data);
	endtask

	// spare indexes must leave the coefficients alone
	task automatic program_filter(input logic signed [COEF_WIDTH-1:0] b0, b1, b2, a1, a2,
		input bit poke_spare);
		int i;
		write_coef(IDX_B0, b0);
		write_coef(IDX_B1, b1);
		write_coef(IDX_B2, b2);
		write_coef(IDX_A1, a1);
		write_coef(IDX_A2, a2);
		if (poke_spare) begin
			for (i = NUM_COEFS; i < NUM_IDX; i++)
				write_coef(IDX_W'(i), COEF_WIDTH'($urandom));
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
		sample_queue.push_back(x);
		items_queued++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (items_taken != items_queued || expected_out.size() != 0)
			@(negedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold until transfer
		end else if (tx_gap > 0) begin
			in_valid <= 1'b0;
			tx_gap = tx_gap - 1;
		end else if (sample_queue.size() > 0) begin
			sample_in <= sample_queue.pop_front();
			in_valid  <= 1'b1;
			if (!tx_steady && $urandom_range(0, 2) == 0)
				tx_gap = pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			rx_hold   = LONG_HOLD;
		end
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if (rx_steady || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
		end else begin
			rx_hold   = pick_gap() - 1;
			out_ready <= 1'b0;
		end
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_out.push_back(filter_step(sample_in));
				items_taken <= items_taken + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_out.size() == 0) begin
					$display("%0t: sample_out %0d with nothing expected", $time, sample_out);
					errors++;
				end else begin
					wanted = expected_out.pop_front();
					if (sample_out !== wanted) begin
						$display("%0t: sample_out mismatch: expected %0d, got %0d",
							$time, wanted, sample_out);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int phase;
		int n;
		int kind;
		int lim;
		int a1v;
		int a2v;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset coefficients: straight pass-through
		queue_sample('0);
		queue_sample(SMP_MAX);
		queue_sample(SMP_MIN);
		queue_sample(SAMPLE_WIDTH'(1));
		queue_sample(-SAMPLE_WIDTH'(1));
		queue_sample(SAMPLE_WIDTH'(24'h555555));
		queue_sample(SAMPLE_WIDTH'(24'hAAAAAA));
		wait_idle();

		// half gain: rounding ties either side of zero
		program_filter(COEF_ONE >>> 1, '0, '0, '0, '0, 1'b1);
		queue_sample(SAMPLE_WIDTH'(1));
		queue_sample(-SAMPLE_WIDTH'(1));
		queue_sample(SAMPLE_WIDTH'(3));
		queue_sample(-SAMPLE_WIDTH'(3));
		wait_idle();

		// extreme coefficients: history and output saturation
		program_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b0);
		repeat (3) queue_sample(SMP_MAX);
		repeat (3) queue_sample(SMP_MIN);
		wait_idle();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				program_filter(extreme_coef(), extreme_coef(), extreme_coef(),
					extreme_coef(), extreme_coef(), 1'b0);
			end else if (kind == 1) begin
				program_filter(COEF_WIDTH'($urandom), COEF_WIDTH'($urandom),
					COEF_WIDTH'($urandom), COEF_WIDTH'($urandom), COEF_WIDTH'($urandom),
					$urandom_range(0, 1));
			end else begin
				// poles inside the stability triangle
				a2v = int'($urandom_range(0, ONE * 9 / 5)) - ONE * 9 / 10;
				lim = (ONE + a2v) * 95 / 100;
				a1v = int'($urandom_range(0, 2 * lim)) - lim;
				program_filter(rand_gain(), rand_gain(), rand_gain(),
					COEF_WIDTH'(a1v), COEF_WIDTH'(a2v), 1'b0);
			end
			tx_steady = (phase % 3 == 1) || (phase == BURST_PHASE);
			rx_steady = (phase % 3 == 1);
			if (phase == BURST_PHASE)
				hold_asked++;
			for (n = 0; n < PHASE_ITEMS; n++)
				queue_sample(rand_sample());
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_out.size() != 0) begin
			$display("%0t: %0d expected samples never arrived", $time, expected_out.size());
			errors++;
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
